### hdl/battery_cell_voltage_collector_top_assert.svh
`ifndef BATTERY_CELL_VOLTAGE_COLLECTOR_TOP_ASSERT_SVH
`define BATTERY_CELL_VOLTAGE_COLLECTOR_TOP_ASSERT_SVH

// same-cycle implication, checked on every edge outside reset
`define BCVC_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("bcvc assertion failed");

// implication into the following cycle
`define BCVC_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("bcvc assertion failed");

`endif

### hdl/bcvc_pkg.sv
package bcvc_pkg;

  localparam int unsigned CELL_W       = 16;
  localparam int unsigned ID_W         = 29;
  localparam int unsigned SUM_W        = 21;
  localparam int unsigned GROUP_SIZE   = 4;
  localparam int unsigned GSUM_W       = CELL_W + 2;
  localparam logic [4:0]  NIBBLE_BIAS  = 5'd9;
  localparam logic [4:0]  HALF_GROUPS  = 5'd3;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [ID_W-1:0]   frame_id;
    logic [CELL_W-1:0] cell_a;
    logic [CELL_W-1:0] cell_b;
    logic [CELL_W-1:0] cell_c;
    logic [CELL_W-1:0] cell_d;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [SUM_W-1:0]  series_sum;
    logic              all_present;
  } out_item_t;

endpackage

### hdl/bcvc_bank.sv
module bcvc_bank
  import bcvc_pkg::*;
#(
  parameter int unsigned NUM_CELLS = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      commit,
  input  in_item_t  item,
  output out_item_t res,
  output logic      ready
);

  localparam int unsigned NUM_GROUPS = NUM_CELLS / GROUP_SIZE;
  localparam int unsigned GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned RAW_TOT_W  = $clog2(NUM_GROUPS * GROUP_SIZE * 65535 + 1);
  localparam int unsigned TOT_W      = (RAW_TOT_W > SUM_W) ? RAW_TOT_W : SUM_W;
  localparam logic        FULL_COVER = ((NUM_CELLS % GROUP_SIZE) == 0);

  // per-group sum of the four stored cells, and one seen bit per group
  logic [GSUM_W-1:0]     gsum [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] seen;
  logic [NUM_GROUPS-1:0] seen_next;
  logic [TOT_W-1:0]      total;
  logic [TOT_W-1:0]      total_next;
  logic                  ready_next;

  logic [4:0]            shifted;
  logic [4:0]            offset;
  logic [GIDX_W-1:0]     gidx;
  logic                  hit;
  logic [GSUM_W-1:0]     new_gsum;
  logic [GSUM_W-1:0]     old_gsum;

  always_comb begin
    shifted  = {1'b0, item.frame_id[11:8]} + (item.frame_id[0] ? HALF_GROUPS : 5'd0);
    offset   = shifted - NIBBLE_BIAS;
    hit      = (shifted >= NIBBLE_BIAS) && (offset < 5'(NUM_GROUPS));
    gidx     = offset[GIDX_W-1:0];
    new_gsum = GSUM_W'(item.cell_a) + GSUM_W'(item.cell_b)
             + GSUM_W'(item.cell_c) + GSUM_W'(item.cell_d);
    old_gsum = hit ? gsum[gidx] : '0;

    seen_next  = seen;
    total_next = total;
    if (hit) begin
      seen_next[gidx] = 1'b1;
      total_next = total - TOT_W'(old_gsum) + TOT_W'(new_gsum);
    end
    ready_next = ready | (hit & FULL_COVER & (&seen_next));

    res.accepted    = hit;
    res.series_sum  = (total_next > TOT_W'(SUM_MAX)) ? SUM_MAX : total_next[SUM_W-1:0];
    res.all_present = ready_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= '0;
      total <= '0;
      ready <= 1'b0;
    end else if (commit) begin
      seen  <= seen_next;
      total <= total_next;
      ready <= ready_next;
    end
  end

  // group sums reset too: cells read as zero before first write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        gsum[i] <= '0;
      end
    end else if (commit && hit) begin
      gsum[gidx] <= new_gsum;
    end
  end

endmodule

### hdl/battery_cell_voltage_collector_top.sv
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------
// frame    | frame_valid / stall | in_item_t: frame_id, cell_a .. cell_d
// result   | result_valid / stall| out_item_t: accepted, series_sum, all_present
//
// one item per cycle while result_stall is low; the result passes through the input
// register and the result register around the group update
// the running total is patched by one group sum a cycle while items advance, so no
// adder tree spans all cells
// rst is synchronous: clears the seen marks, group sums, total and ready flag
// a stalled result holds; frame_stall rises only while a finished item waits
module battery_cell_voltage_collector_top
  import bcvc_pkg::*;
#(
  parameter int unsigned NUM_CELLS = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      frame_valid,
  output logic      frame_stall,
  input  in_item_t  frame,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  `include "battery_cell_voltage_collector_top_assert.svh"

  // input register
  logic      s1_valid;
  logic      s1_valid_next;
  in_item_t  s1_item;

  // bank result for the item in the input register
  out_item_t bank_res;
  logic      bank_ready;

  logic      take_in;
  logic      advance;
  logic      result_valid_next;

  always_comb begin
    // item moves on when the result register is empty or being drained
    advance           = s1_valid && (!result_valid || !result_stall);
    frame_stall       = s1_valid && !advance;
    take_in           = frame_valid && !frame_stall;
    s1_valid_next     = take_in || (s1_valid && !advance);
    result_valid_next = advance || (result_valid && result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= s1_valid_next;
      result_valid <= result_valid_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_item <= frame;
    end
    if (advance) begin
      result <= bank_res;
    end
  end

  // state update commits in the same edge the result is captured
  bcvc_bank #(
    .NUM_CELLS(NUM_CELLS)
  ) u_bank (
    .clk   (clk),
    .rst   (rst),
    .commit(advance),
    .item  (s1_item),
    .res   (bank_res),
    .ready (bank_ready)
  );

  // back-pressure only comes from a full input register
  `BCVC_ASSERT_NOW(a_stall_needs_item, clk, rst, frame_stall, s1_valid)
  // the ready flag is sticky until reset
  `BCVC_ASSERT_NEXT(a_ready_sticky, clk, rst, bank_ready, bank_ready)
  // a new result always comes from an item that sat in the input register
  `BCVC_ASSERT_NOW(a_result_source, clk, rst, $rose(result_valid), $past(s1_valid))

endmodule
